/* hdl/ssbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ssbc_pkg;

    // Commutation sequence length
    localparam int unsigned NUM_STEPS = 6;

    // Operating modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_ALIGN = 3'd1;
    localparam logic [2:0] MODE_READY = 3'd2;
    localparam logic [2:0] MODE_RAMP  = 3'd3;
    localparam logic [2:0] MODE_RUN   = 3'd4;

    // Input operations
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_CAPTURE = 2'd1;
    localparam logic [1:0] OP_ALIGN   = 2'd2;
    localparam logic [1:0] OP_STARTUP = 2'd3;

    // Phase codes
    localparam logic [1:0] PHASE_U = 2'd0;
    localparam logic [1:0] PHASE_V = 2'd1;
    localparam logic [1:0] PHASE_W = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ALIGN_DUTY      = 3'd0;
    localparam logic [2:0] CFG_ALIGN_TICKS     = 3'd1;
    localparam logic [2:0] CFG_RAMP_DUTY_START = 3'd2;
    localparam logic [2:0] CFG_RAMP_DUTY_END   = 3'd3;
    localparam logic [2:0] CFG_RAMP_DUTY_INC   = 3'd4;
    localparam logic [2:0] CFG_RAMP_PER_START  = 3'd5;
    localparam logic [2:0] CFG_RAMP_PER_FINAL  = 3'd6;
    localparam logic [2:0] CFG_RAMP_PER_DEC    = 3'd7;

    localparam logic [11:0] DUTY_MAX  = 12'hFFF;
    localparam logic [15:0] WRAP_BASE = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  zc_phase;
        logic [15:0] capture_count;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  pwm_phase;
        logic [1:0]  sink_phase;
        logic [2:0]  enable_mask;
        logic [11:0] duty;
        logic [15:0] interval;
    } result_t;

    typedef struct packed {
        logic [11:0] align_duty;
        logic [15:0] align_ticks;
        logic [11:0] ramp_duty_start;
        logic [11:0] ramp_duty_end;
        logic [11:0] ramp_duty_increment;
        logic [15:0] ramp_period_start;
        logic [15:0] ramp_period_final;
        logic [15:0] ramp_period_decrement;
    } cfg_t;

    // PWM phase of each step: UV, UW, VW, VU, WU, WV
    function automatic logic [1:0] step_hi(input logic [2:0] s);
        case (s)
            3'd0, 3'd1: step_hi = PHASE_U;
            3'd2, 3'd3: step_hi = PHASE_V;
            3'd4, 3'd5: step_hi = PHASE_W;
            default:    step_hi = PHASE_U;
        endcase
    endfunction

    // Sink phase of each step
    function automatic logic [1:0] step_lo(input logic [2:0] s);
        case (s)
            3'd0, 3'd5: step_lo = PHASE_V;
            3'd1, 3'd2: step_lo = PHASE_W;
            3'd3, 3'd4: step_lo = PHASE_U;
            default:    step_lo = PHASE_V;
        endcase
    endfunction

    // One-hot floating phase of each step
    function automatic logic [2:0] step_float_mask(input logic [2:0] s);
        case (s)
            3'd0, 3'd3: step_float_mask = 3'b100;
            3'd1, 3'd4: step_float_mask = 3'b010;
            3'd2, 3'd5: step_float_mask = 3'b001;
            default:    step_float_mask = 3'b100;
        endcase
    endfunction

    // Advance the step modulo the sequence length
    function automatic logic [2:0] next_step(input logic [2:0] s);
        if (s >= 3'(NUM_STEPS - 1)) begin
            next_step = 3'd0;
        end else begin
            next_step = s + 3'd1;
        end
    endfunction

    // Add the duty increment while below the end value, saturate at full scale
    function automatic logic [11:0] grow_duty(input logic [11:0] duty,
                                              input logic [11:0] dend,
                                              input logic [11:0] inc);
        logic [12:0] sum;
        sum = {1'b0, duty} + {1'b0, inc};
        if (duty < dend) begin
            grow_duty = sum[12] ? DUTY_MAX : sum[11:0];
        end else begin
            grow_duty = duty;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/ssbc_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssbc_core (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 fire,
    input  ssbc_pkg::in_item_t  item,
    input  ssbc_pkg::cfg_t      cfg,
    output ssbc_pkg::result_t   res_next
);
    import ssbc_pkg::*;

    logic [2:0]  mode_reg, mode_next;
    logic [2:0]  step_reg, step_next;
    logic [11:0] duty_reg, duty_next;
    logic [15:0] period_reg, period_next;
    logic [15:0] countdown_reg, countdown_next;
    logic [2:0]  float_reg, float_next;
    logic [15:0] prev_cap_reg, prev_cap_next;
    logic [15:0] interval_reg, interval_next;
    logic        pending_reg, pending_next;
    logic        drive_reg, drive_next;

    logic        wait_done;
    logic [15:0] countdown_dec;
    logic [2:0]  ramp_s1;
    logic [11:0] ramp_d1;
    logic [15:0] period_sub;
    logic        cap_hit;

    // Countdown and ramp helpers
    assign wait_done     = (countdown_reg <= 16'd1);
    assign countdown_dec = countdown_reg - 16'd1;
    assign ramp_s1       = drive_reg ? next_step(step_reg) : step_reg;
    assign ramp_d1       = drive_reg ? grow_duty(duty_reg, cfg.ramp_duty_end,
                                                 cfg.ramp_duty_increment) : duty_reg;
    assign period_sub    = (period_reg > cfg.ramp_period_decrement)
                         ? period_reg - cfg.ramp_period_decrement : 16'd0;
    assign cap_hit       = (item.zc_phase != 2'd3) && float_reg[item.zc_phase];

    // Next state for the current beat
    always_comb begin
        mode_next      = mode_reg;
        step_next      = step_reg;
        duty_next      = duty_reg;
        period_next    = period_reg;
        countdown_next = countdown_reg;
        float_next     = float_reg;
        prev_cap_next  = prev_cap_reg;
        interval_next  = interval_reg;
        pending_next   = pending_reg;
        drive_next     = drive_reg;

        case (item.op)
            OP_TICK: begin
                if (mode_reg == MODE_ALIGN) begin
                    if (!wait_done) begin
                        countdown_next = countdown_dec;
                    end else begin
                        countdown_next = 16'd0;
                        drive_next     = 1'b0;
                        if (pending_reg) begin
                            pending_next   = 1'b0;
                            mode_next      = MODE_RAMP;
                            duty_next      = cfg.ramp_duty_start;
                            step_next      = 3'd0;
                            period_next    = cfg.ramp_period_start;
                            countdown_next = cfg.ramp_period_start;
                        end else begin
                            mode_next = MODE_READY;
                        end
                    end
                end else if (mode_reg == MODE_RAMP) begin
                    if (!wait_done) begin
                        countdown_next = countdown_dec;
                    end else if (period_reg > cfg.ramp_period_final) begin
                        step_next      = ramp_s1;
                        duty_next      = ramp_d1;
                        float_next     = step_float_mask(ramp_s1);
                        drive_next     = 1'b1;
                        period_next    = period_sub;
                        countdown_next = period_sub;
                    end else begin
                        // Last ramp commutation: advance once more, then float all
                        countdown_next = 16'd0;
                        step_next      = next_step(ramp_s1);
                        duty_next      = grow_duty(ramp_d1, cfg.ramp_duty_end,
                                                   cfg.ramp_duty_increment);
                        drive_next     = 1'b0;
                        float_next     = 3'b111;
                        mode_next      = MODE_RUN;
                    end
                end
            end
            OP_CAPTURE: begin
                if (cap_hit) begin
                    if (mode_reg == MODE_RUN) begin
                        step_next  = next_step(step_reg);
                        float_next = step_float_mask(next_step(step_reg));
                        drive_next = 1'b1;
                    end
                    if (item.zc_phase == PHASE_W) begin
                        if (item.capture_count >= prev_cap_reg) begin
                            interval_next = item.capture_count - prev_cap_reg;
                        end else begin
                            interval_next = WRAP_BASE - prev_cap_reg + item.capture_count;
                        end
                        prev_cap_next = item.capture_count;
                    end
                end
            end
            default: begin
                if (mode_reg == MODE_IDLE || mode_reg == MODE_READY) begin
                    pending_next   = (item.op == OP_STARTUP);
                    mode_next      = MODE_ALIGN;
                    step_next      = 3'd0;
                    float_next     = step_float_mask(3'd0);
                    drive_next     = 1'b1;
                    countdown_next = cfg.align_ticks;
                end
            end
        endcase
    end

    // Result fields from the updated state
    always_comb begin
        res_next.mode     = mode_next;
        res_next.interval = interval_next;
        if (drive_next) begin
            res_next.pwm_phase   = step_hi(step_next);
            res_next.sink_phase  = step_lo(step_next);
            res_next.enable_mask = (3'b001 << step_hi(step_next))
                                 | (3'b001 << step_lo(step_next));
            res_next.duty        = (mode_next == MODE_ALIGN) ? cfg.align_duty : duty_next;
        end else begin
            res_next.pwm_phase   = PHASE_U;
            res_next.sink_phase  = PHASE_U;
            res_next.enable_mask = 3'b000;
            res_next.duty        = 12'd0;
        end
    end

    // Commit state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            step_reg      <= 3'd0;
            duty_reg      <= 12'd0;
            period_reg    <= 16'd0;
            countdown_reg <= 16'd0;
            float_reg     <= 3'b000;
            prev_cap_reg  <= 16'd0;
            interval_reg  <= 16'd0;
            pending_reg   <= 1'b0;
            drive_reg     <= 1'b0;
        end else if (fire) begin
            mode_reg      <= mode_next;
            step_reg      <= step_next;
            duty_reg      <= duty_next;
            period_reg    <= period_next;
            countdown_reg <= countdown_next;
            float_reg     <= float_next;
            prev_cap_reg  <= prev_cap_next;
            interval_reg  <= interval_next;
            pending_reg   <= pending_next;
            drive_reg     <= drive_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/six_step_bldc_commutator.sv */
`timescale 1ns / 1ps
`default_nettype none
// The result is registered: it appears on m_data in the cycle after its beat is accepted.
// Throughput: one beat per cycle unless a held result waits on m_ready; the next state
// comes in one pass from state and input beat; the result register decouples m_ready.
// Reset (aresetn low, synchronous) returns the commutator to idle with the bridge off,
// clears all configuration registers and empties the result register.

module six_step_bldc_commutator (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  ssbc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output ssbc_pkg::result_t   m_data,
    input  wire                 cfg_we,
    input  wire  [2:0]          cfg_index,
    input  wire  [15:0]         cfg_wdata
);
    import ssbc_pkg::*;

    cfg_t    cfg_reg;
    result_t res_next;
    result_t m_data_reg;
    logic    m_valid_reg;
    logic    fire;

    // Accept while the result register is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ALIGN_DUTY:      cfg_reg.align_duty            <= cfg_wdata[11:0];
                CFG_ALIGN_TICKS:     cfg_reg.align_ticks           <= cfg_wdata;
                CFG_RAMP_DUTY_START: cfg_reg.ramp_duty_start       <= cfg_wdata[11:0];
                CFG_RAMP_DUTY_END:   cfg_reg.ramp_duty_end         <= cfg_wdata[11:0];
                CFG_RAMP_DUTY_INC:   cfg_reg.ramp_duty_increment   <= cfg_wdata[11:0];
                CFG_RAMP_PER_START:  cfg_reg.ramp_period_start     <= cfg_wdata;
                CFG_RAMP_PER_FINAL:  cfg_reg.ramp_period_final     <= cfg_wdata;
                CFG_RAMP_PER_DEC:    cfg_reg.ramp_period_decrement <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ssbc_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .item     (s_data),
        .cfg      (cfg_reg),
        .res_next (res_next)
    );

    // Result register: load on accept, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= res_next;
        end
    end

endmodule

`default_nettype wire
